[hw/rtl/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// Widths, payload structs and helpers shared by the temperature
// compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

  localparam int RAW_W      = 16;
  localparam int COEF_W     = 16;
  localparam int DIFF_W     = RAW_W + 1;
  localparam int MULT_W     = DIFF_W + COEF_W + 1;
  localparam int PROD_W     = 33;
  localparam int X1_SHIFT   = 15;
  localparam int X1_W       = PROD_W - X1_SHIFT;
  localparam int DVS_W      = X1_W + 1;
  localparam int DMAG_W     = DVS_W - 1;
  localparam int NUM_SHIFT  = 11;
  localparam int NMAG_W     = COEF_W + NUM_SHIFT;
  localparam int X2_W       = NMAG_W + 1;
  localparam int B5_W       = X2_W + 1;
  localparam int OUT_SHIFT  = 4;
  localparam int TEMP_W     = 32;
  localparam int TSH_W      = B5_W - OUT_SHIFT;
  localparam int USER_W     = 2;
  localparam int DIV_STAGES = NMAG_W;

  localparam logic [B5_W-1:0]     ROUND_ADD = B5_W'(8);
  localparam logic [B5_W-1:0]     TRUNC_ADJ = B5_W'(15);
  localparam logic [COEF_W-1:0]   COEF_ZERO = 16'h0000;
  localparam logic [COEF_W-1:0]   COEF_ONES = 16'hffff;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_AC5 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AC6 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MC  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MD  = 2'd3;

  typedef struct packed {
    logic [X1_W-1:0] x1;
    logic            fault;
    logic            cal_ok;
    logic            q_neg;
  } side_t;

  typedef struct packed {
    logic [NMAG_W-1:0] nmag;
    logic [DMAG_W-1:0] dmag;
    side_t             side;
  } div_in_t;

  typedef struct packed {
    logic [NMAG_W-1:0] nq;
    logic [DMAG_W-1:0] rem;
    logic [DMAG_W-1:0] dmag;
    side_t             side;
  } div_st_t;

  typedef struct packed {
    logic [NMAG_W-1:0] quo;
    side_t             side;
  } quo_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic              fault;
    logic              cal_ok;
  } result_t;

  function automatic logic coef_valid(input logic [COEF_W-1:0] v);
    coef_valid = (v != COEF_ZERO) && (v != COEF_ONES);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ptc_front.sv]
// ----------------------------------------------------------------------------
// ptc_front
// Three-stage front end: offset and scale multiply, truncating divide by
// 32768, then divisor, numerator magnitude and sign setup for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_front
  import ptc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [RAW_W-1:0]  raw,
  input  wire logic [COEF_W-1:0] ac5,
  input  wire logic [COEF_W-1:0] ac6,
  input  wire logic [COEF_W-1:0] mc,
  input  wire logic [COEF_W-1:0] md,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output div_in_t                out_data
);

  logic              vld1, vld2, vld3;
  logic              rdy1, rdy2, rdy3;
  logic [PROD_W-1:0] prod1;
  logic              cal1, cal2;
  logic [X1_W-1:0]   x1_2;
  div_in_t           st3;

  logic signed [DIFF_W-1:0] diff;
  logic signed [MULT_W-1:0] mult;
  logic [PROD_W-1:0]        biased;
  logic [DVS_W-1:0]         dvs;
  logic [DVS_W-1:0]         dabs;
  logic [COEF_W:0]          mcx;
  logic [COEF_W:0]          mabs;
  div_in_t                  st3_next;

  assign rdy3     = !vld3 || out_ready;
  assign rdy2     = !vld2 || rdy3;
  assign rdy1     = !vld1 || rdy2;
  assign in_ready = rdy1;

  assign diff = $signed({1'b0, raw}) - $signed({1'b0, ac6});
  assign mult = diff * $signed({1'b0, ac5});

  assign biased = prod1 + {{(PROD_W - X1_SHIFT){1'b0}}, {X1_SHIFT{prod1[PROD_W-1]}}};

  always_comb begin
    dvs  = {x1_2[X1_W-1], x1_2} + {{(DVS_W - COEF_W){md[COEF_W-1]}}, md};
    dabs = dvs[DVS_W-1] ? (~dvs + 1'b1) : dvs;
    mcx  = {mc[COEF_W-1], mc};
    mabs = mc[COEF_W-1] ? (~mcx + 1'b1) : mcx;
    st3_next.nmag        = {mabs[COEF_W-1:0], {NUM_SHIFT{1'b0}}};
    st3_next.dmag        = dabs[DMAG_W-1:0];
    st3_next.side.x1     = x1_2;
    st3_next.side.fault  = (dvs == '0);
    st3_next.side.cal_ok = cal2;
    st3_next.side.q_neg  = mc[COEF_W-1] ^ dvs[DVS_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      if (rdy1) vld1 <= in_valid;
      if (rdy2) vld2 <= vld1;
      if (rdy3) vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      prod1 <= mult[PROD_W-1:0];
      cal1  <= coef_valid(ac5) && coef_valid(ac6) && coef_valid(mc) && coef_valid(md);
    end
    if (rdy2 && vld1) begin
      x1_2 <= biased[PROD_W-1:X1_SHIFT];
      cal2 <= cal1;
    end
    if (rdy3 && vld2) begin
      st3 <= st3_next;
    end
  end

  assign out_valid = vld3;
  assign out_data  = st3;

endmodule

`default_nettype wire

[hw/rtl/ptc_divider.sv]
// ----------------------------------------------------------------------------
// ptc_divider
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Side data rides along with each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_divider
  import ptc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  div_in_t   in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output quo_t      out_data
);

  logic    vld [1:DIV_STAGES];
  div_st_t st  [1:DIV_STAGES];
  wire     rdy [0:DIV_STAGES];

  assign rdy[DIV_STAGES] = out_ready;
  assign in_ready        = rdy[0];

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    logic           src_v;
    div_st_t        src;
    div_st_t        nxt;
    logic [DMAG_W:0] trial;
    logic [DMAG_W:0] sub;
    logic            ge;

    if (k == 1) begin : g_first
      assign src_v     = in_valid;
      assign src.nq    = in_data.nmag;
      assign src.rem   = '0;
      assign src.dmag  = in_data.dmag;
      assign src.side  = in_data.side;
    end else begin : g_next
      assign src_v = vld[k-1];
      assign src   = st[k-1];
    end

    assign rdy[k-1] = !vld[k] || rdy[k];

    always_comb begin
      trial    = {src.rem, src.nq[NMAG_W-1]};
      sub      = trial - {1'b0, src.dmag};
      ge       = (trial >= {1'b0, src.dmag});
      nxt.nq   = {src.nq[NMAG_W-2:0], ge};
      nxt.rem  = ge ? sub[DMAG_W-1:0] : trial[DMAG_W-1:0];
      nxt.dmag = src.dmag;
      nxt.side = src.side;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k-1]) begin
        vld[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k-1] && src_v) begin
        st[k] <= nxt;
      end
    end
  end

  assign out_valid     = vld[DIV_STAGES];
  assign out_data.quo  = st[DIV_STAGES].nq;
  assign out_data.side = st[DIV_STAGES].side;

endmodule

`default_nettype wire

[hw/rtl/ptc_back.sv]
// ----------------------------------------------------------------------------
// ptc_back
// Three-stage back end: signed quotient, x1 + x2, then rounding and
// truncating divide by 16. The last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_back
  import ptc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  quo_t      in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   out_data
);

  logic            vld1, vld2, vld3;
  logic            rdy1, rdy2, rdy3;
  logic [X2_W-1:0] x2_1;
  side_t           side1;
  logic [B5_W-1:0] b5_2;
  logic            fault2, cal2;
  result_t         res3;

  logic [X2_W-1:0] qext;
  logic [B5_W-1:0] rnd;
  logic [B5_W-1:0] adj;
  result_t         res_next;

  assign rdy3     = !vld3 || out_ready;
  assign rdy2     = !vld2 || rdy3;
  assign rdy1     = !vld1 || rdy2;
  assign in_ready = rdy1;

  assign qext = {1'b0, in_data.quo};

  always_comb begin
    rnd             = b5_2 + ROUND_ADD;
    adj             = rnd[B5_W-1] ? (rnd + TRUNC_ADJ) : rnd;
    res_next.temp   = fault2 ? '0 : {{(TEMP_W - TSH_W){adj[B5_W-1]}}, adj[B5_W-1:OUT_SHIFT]};
    res_next.fault  = fault2;
    res_next.cal_ok = cal2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      if (rdy1) vld1 <= in_valid;
      if (rdy2) vld2 <= vld1;
      if (rdy3) vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      x2_1  <= in_data.side.q_neg ? (~qext + 1'b1) : qext;
      side1 <= in_data.side;
    end
    if (rdy2 && vld1) begin
      b5_2   <= {{(B5_W - X1_W){side1.x1[X1_W-1]}}, side1.x1} + {x2_1[X2_W-1], x2_1};
      fault2 <= side1.fault;
      cal2   <= side1.cal_ok;
    end
    if (rdy3 && vld2) begin
      res3 <= res_next;
    end
  end

  assign out_valid = vld3;
  assign out_data  = res3;

endmodule

`default_nettype wire

[hw/rtl/pressure_sensor_temp_compensation.sv]
// ----------------------------------------------------------------------------
// pressure_sensor_temp_compensation
// Compensated temperature from a raw reading and four calibration
// coefficients, as a fully pipelined stream block.
//
//   channel   dir  fields (low bit up)
//   s_*       in   tdata: raw_temperature[15:0]
//   m_*       out  tdata: temperature[31:0]; tuser: divide_fault, calibration_ok
//   cfg_*     in   index 0 ac5, 1 ac6, 2 mc, 3 md; wdata[15:0]
//
// One transaction per cycle sustained while m_tready is held high. A reading
// passes 3 front stages, 27 divider stages at one quotient bit each and 3
// back stages before its result is offered on m_*. Synchronous reset clears
// all valid bits and the coefficients. Each stage holds under stall and empty
// stages still fill, so s_tready stays high while any stage has room.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_sensor_temp_compensation
  import ptc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [RAW_W-1:0]     s_tdata,   // raw_temperature
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [TEMP_W-1:0]         m_tdata,   // temperature
  output logic [USER_W-1:0]         m_tuser,   // divide_fault, calibration_ok
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_wdata
);

  logic [COEF_W-1:0] ac5, ac6, mc, md;

  logic    f_valid, f_ready;
  div_in_t f_data;
  logic    d_valid, d_ready;
  quo_t    d_data;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac5 <= '0;
      ac6 <= '0;
      mc  <= '0;
      md  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AC5: ac5 <= cfg_wdata;
        REG_AC6: ac6 <= cfg_wdata;
        REG_MC:  mc  <= cfg_wdata;
        REG_MD:  md  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ptc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .raw       (s_tdata),
    .ac5       (ac5),
    .ac6       (ac6),
    .mc        (mc),
    .md        (md),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  ptc_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  ptc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_data   (d_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = res.temp;
  assign m_tuser = {res.cal_ok, res.fault};

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("divide fault with nonzero temperature");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_fill_path: assert property (@(posedge clk) disable iff (rst)
    !f_valid |-> s_tready)
    else $error("front end stalled while its last stage is empty");

endmodule

`default_nettype wire
